// ===== rtl/lfmr_pkg.sv =====
package lfmr_pkg;

    // Frame buffer size and the counter that addresses it
    localparam int BUFFER_DEPTH = 1024;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int IDLE_W       = 17;
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // Field widths
    localparam int INDEX_W  = 10;
    localparam int MLEN_W   = 11;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Frame events
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_REJECT   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_COMPLETE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW = 3'd4;

    // Frame phases
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHECK  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_END   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_HIGH_1ST = 8'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic               write_valid;
        logic [INDEX_W-1:0] write_index;
        logic [7:0]         write_byte;
        logic [EVENT_W-1:0] frame_event;
        logic               message_ready;
        logic [MLEN_W-1:0]  message_length;
    } out_item_t;

endpackage

// ===== rtl/length_framed_message_receiver.sv =====
// Length-framed serial message receiver.
// Input channel (in_valid/in_ready/in_data): one transaction is either a
// received byte or a poll. Output channel (out_valid/out_ready/out_data):
// exactly one result per input transaction, in order. Each byte result
// carries the buffer index for an external frame buffer and any frame event
// (start rejected, complete, overflow drop); a poll result reports a pending
// completed message and its length, and may carry a timeout drop.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while the block is idle. Unknown indexes are ignored.
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while results are taken, set by the single result register;
// the frame state is updated in the same cycle the item is taken.
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; in_ready is high whenever the result register
// is empty or being emptied in the same cycle.
// Reset clears the frame state, the pending message and the result valid
// flag, and loads the register defaults.
module length_framed_message_receiver
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lfmr_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lfmr_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfmr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfmr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [7:0]  start_byte_reg;
    logic [4:0]  start_check_reg;
    logic [4:0]  header_end_reg;
    logic [7:0]  trailer_reg;
    logic [15:0] timeout_reg;
    logic        len_high_first_reg;

    // Frame state
    logic [lfmr_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [7:0]                   first_byte_reg, first_byte_next;
    logic [7:0]                   len_two_reg, len_two_next;
    logic [7:0]                   len_three_reg, len_three_next;
    logic [15:0]                  expected_reg, expected_next;
    logic [lfmr_pkg::IDLE_W-1:0]  idle_polls_reg, idle_polls_next;
    logic                         waiting_reg, waiting_next;
    logic                         pending_reg, pending_next;
    logic [lfmr_pkg::MLEN_W-1:0]  last_length_reg, last_length_next;

    // Result register
    logic                out_valid_reg;
    lfmr_pkg::out_item_t out_data_reg, out_data_next;

    logic                         in_fire;
    logic [lfmr_pkg::COUNT_W-1:0] count_inc;
    logic [31:0]                  frame_size;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign count_inc  = byte_count_reg + lfmr_pkg::COUNT_W'(1);
    assign frame_size = 32'(expected_reg) + 32'(trailer_reg);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg     <= 8'd0;
            start_check_reg    <= 5'd1;
            header_end_reg     <= 5'd4;
            trailer_reg        <= 8'd4;
            timeout_reg        <= 16'd1000;
            len_high_first_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lfmr_pkg::REG_START_BYTE:   start_byte_reg     <= cfg_data[7:0];
                lfmr_pkg::REG_START_CHECK:  start_check_reg    <= cfg_data[4:0];
                lfmr_pkg::REG_HEADER_END:   header_end_reg     <= cfg_data[4:0];
                lfmr_pkg::REG_TRAILER:      trailer_reg        <= cfg_data[7:0];
                lfmr_pkg::REG_TIMEOUT:      timeout_reg        <= cfg_data;
                lfmr_pkg::REG_LEN_HIGH_1ST: len_high_first_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Work out the next frame state and the result for the offered item
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        phase_next       = phase_reg;
        first_byte_next  = first_byte_reg;
        len_two_next     = len_two_reg;
        len_three_next   = len_three_reg;
        expected_next    = expected_reg;
        idle_polls_next  = idle_polls_reg;
        waiting_next     = waiting_reg;
        pending_next     = pending_reg;
        last_length_next = last_length_reg;
        out_data_next    = '0;

        if (in_data.kind == lfmr_pkg::KIND_BYTE)
        begin
            if (32'(byte_count_reg) >= 32'(lfmr_pkg::BUFFER_DEPTH))
            begin
                // Drop the frame on buffer overflow
                byte_count_next           = '0;
                expected_next             = '0;
                idle_polls_next           = '0;
                waiting_next              = 1'b0;
                phase_next                = lfmr_pkg::PH_START;
                out_data_next.frame_event = lfmr_pkg::EV_OVERFLOW;
            end
            else
            begin
                waiting_next              = 1'b1;
                idle_polls_next           = '0;
                out_data_next.write_valid = 1'b1;
                out_data_next.write_index = lfmr_pkg::INDEX_W'(byte_count_reg);
                out_data_next.write_byte  = in_data.data_byte;
                if (byte_count_reg == lfmr_pkg::COUNT_W'(0))
                begin
                    first_byte_next = in_data.data_byte;
                end
                if (byte_count_reg == lfmr_pkg::COUNT_W'(2))
                begin
                    len_two_next = in_data.data_byte;
                end
                if (byte_count_reg == lfmr_pkg::COUNT_W'(3))
                begin
                    len_three_next = in_data.data_byte;
                end
                byte_count_next = count_inc;

                case (phase_reg)
                    lfmr_pkg::PH_START:
                    begin
                        if (32'(count_inc) == 32'(start_check_reg))
                        begin
                            if (first_byte_next != start_byte_reg)
                            begin
                                byte_count_next           = '0;
                                expected_next             = '0;
                                idle_polls_next           = '0;
                                waiting_next              = 1'b0;
                                phase_next                = lfmr_pkg::PH_START;
                                out_data_next.frame_event = lfmr_pkg::EV_REJECT;
                            end
                            else
                            begin
                                phase_next = lfmr_pkg::PH_HEADER;
                            end
                        end
                    end
                    lfmr_pkg::PH_HEADER:
                    begin
                        if (32'(count_inc) == 32'(header_end_reg))
                        begin
                            if (len_high_first_reg)
                            begin
                                expected_next = {len_two_next, len_three_next};
                            end
                            else
                            begin
                                expected_next = {len_three_next, len_two_next};
                            end
                            phase_next = lfmr_pkg::PH_BODY;
                        end
                    end
                    default:
                    begin
                        if (32'(count_inc) == frame_size)
                        begin
                            pending_next              = 1'b1;
                            last_length_next          = lfmr_pkg::MLEN_W'(count_inc);
                            byte_count_next           = '0;
                            expected_next             = '0;
                            idle_polls_next           = '0;
                            waiting_next              = 1'b0;
                            phase_next                = lfmr_pkg::PH_START;
                            out_data_next.frame_event = lfmr_pkg::EV_COMPLETE;
                        end
                    end
                endcase
            end
        end
        else
        begin
            // Age the timeout, or drop a stale partial frame
            if (waiting_reg)
            begin
                if (32'(idle_polls_reg) >= 32'(timeout_reg))
                begin
                    last_length_next          = '0;
                    byte_count_next           = '0;
                    expected_next             = '0;
                    idle_polls_next           = '0;
                    waiting_next              = 1'b0;
                    phase_next                = lfmr_pkg::PH_START;
                    out_data_next.frame_event = lfmr_pkg::EV_TIMEOUT;
                end
                else if (idle_polls_reg != lfmr_pkg::IDLE_MAX)
                begin
                    idle_polls_next = idle_polls_reg + lfmr_pkg::IDLE_W'(1);
                end
            end
            else
            begin
                if (byte_count_reg != '0)
                begin
                    out_data_next.frame_event = lfmr_pkg::EV_TIMEOUT;
                end
                byte_count_next = '0;
                expected_next   = '0;
                idle_polls_next = '0;
                waiting_next    = 1'b0;
                phase_next      = lfmr_pkg::PH_START;
            end

            // Report a pending message
            if (pending_reg)
            begin
                waiting_next                 = 1'b0;
                pending_next                 = 1'b0;
                out_data_next.message_ready  = 1'b1;
                out_data_next.message_length = last_length_next;
            end
        end
    end

    // Advance the frame state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            phase_reg       <= lfmr_pkg::PH_START;
            first_byte_reg  <= '0;
            len_two_reg     <= '0;
            len_three_reg   <= '0;
            expected_reg    <= '0;
            idle_polls_reg  <= '0;
            waiting_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            last_length_reg <= '0;
        end
        else if (in_fire)
        begin
            byte_count_reg  <= byte_count_next;
            phase_reg       <= phase_next;
            first_byte_reg  <= first_byte_next;
            len_two_reg     <= len_two_next;
            len_three_reg   <= len_three_next;
            expected_reg    <= expected_next;
            idle_polls_reg  <= idle_polls_next;
            waiting_reg     <= waiting_next;
            pending_reg     <= pending_next;
            last_length_reg <= last_length_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(byte_count_reg) <= 32'(lfmr_pkg::BUFFER_DEPTH))
        else $error("byte count beyond buffer depth");

    a_write_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.write_valid) |->
        (out_data_reg.frame_event != lfmr_pkg::EV_TIMEOUT &&
         out_data_reg.frame_event != lfmr_pkg::EV_OVERFLOW &&
         !out_data_reg.message_ready))
        else $error("byte write combined with drop or report");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != lfmr_pkg::PH_START) |-> (byte_count_reg != '0))
        else $error("header or body phase with empty frame");

endmodule
